@@ design/event_rate_stationarity_monitor_defines.svh @@
// assertion macros used by the monitor's top-level rtl file
// no dependencies; included by the top level, which carries the concurrent checks
`ifndef EVENT_RATE_STATIONARITY_MONITOR_DEFINES_SVH
`define EVENT_RATE_STATIONARITY_MONITOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ERSM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ersm check failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define ERSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ersm check failed: next-cycle implication");

`endif

@@ design/ersm_pkg.sv @@
// shared widths, codes and request/response types of the event rate monitor
// no dependencies; imported by every module of the block
package ersm_pkg;

    localparam int TIME_BITS  = 48;
    localparam int COUNT_BITS = 32;
    localparam int FRAC_BITS  = 16;

    localparam int SIZE_BITS  = 16;
    localparam int LIMIT_BITS = 8;
    localparam int CFG_BITS   = 16;
    localparam int CFG_IDX_BITS = 2;

    localparam int NUM_BITS = (COUNT_BITS > SIZE_BITS) ? COUNT_BITS : SIZE_BITS;
    localparam int DIV_BITS = NUM_BITS + FRAC_BITS;
    localparam int SAT_BITS = (DIV_BITS > TIME_BITS) ? DIV_BITS : TIME_BITS;

    localparam int IN_TDATA_BITS = ((TIME_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = COUNT_BITS + TIME_BITS + 1 + LIMIT_BITS + TIME_BITS + 1
                              + TIME_BITS + 2;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_DATA_SIZE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MATCH_LIMIT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD   = 2'd2;

    localparam logic [LIMIT_BITS-1:0] MATCH_LIMIT_RST = 8'd255;
    localparam logic [LIMIT_BITS-1:0] THRESHOLD_RST   = 8'd3;

    // status codes
    localparam logic AST_VALID      = 1'b0;
    localparam logic AST_NO_ADVANCE = 1'b1;
    localparam logic [1:0] SST_VALID      = 2'd0;
    localparam logic [1:0] SST_NO_ADVANCE = 2'd1;
    localparam logic [1:0] SST_FEW_EVENTS = 2'd2;

    typedef struct packed {
        logic                 start;
        logic [TIME_BITS-1:0] stamp_now;
        logic [TIME_BITS-1:0] stamp_base;
        logic [TIME_BITS-1:0] lag_ref;
    } lag_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 equal;
        logic [TIME_BITS-1:0] lag;
    } lag_rsp_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_BITS-1:0]  num;
        logic [TIME_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic [TIME_BITS-1:0] quot;
    } div_rsp_t;

endpackage

@@ design/event_rate_stationarity_monitor.sv @@
// top level of the event rate and stationarity monitor
// depends on ersm_pkg, ersm_lag_serial, ersm_divider and the defines header
//
// channel  dir  handshake           payload
// s_       in   s_tvalid/s_tready   s_tdata: event_time
// m_       out  m_tvalid/m_tready   m_tdata: count, period, flags, rates, status
// cfg_     in   cfg_wen             cfg_index, cfg_wdata (no wait, no read-back)
//
// one event at a time; an accepted event goes through the bit-serial lag unit
//   (running alongside the average-rate division), followed by the stationary-rate
//   division when at least two events have been seen and the time has advanced
// the divider is one shared unit producing one quotient bit per cycle
// rst_n clears the counters, lag state and handshake; config returns to its defaults
// a finished result parks in the output register while the next event is accepted;
//   the core waits in its done state only if the previous result is still untaken
`include "event_rate_stationarity_monitor_defines.svh"

module event_rate_stationarity_monitor (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [ersm_pkg::IN_TDATA_BITS-1:0]    s_tdata,  // event_time
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // event_count, period, stationary, equal_lags, average_rate,
    // average_status, stationary_rate, stationary_status
    output logic [ersm_pkg::OUT_TDATA_BITS-1:0]   m_tdata,
    input  logic                                  cfg_wen,
    input  logic [ersm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [ersm_pkg::CFG_BITS-1:0]         cfg_wdata
);
    import ersm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_SDIV = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [SIZE_BITS-1:0]  data_size_reg, data_size_next;
    logic [LIMIT_BITS-1:0] match_limit_reg, match_limit_next;
    logic [LIMIT_BITS-1:0] threshold_reg, threshold_next;

    // monitor state
    logic [COUNT_BITS-1:0] events_seen_reg, events_seen_next;
    logic [TIME_BITS-1:0]  last_time_reg, last_time_next;
    logic [TIME_BITS-1:0]  last_lag_reg, last_lag_next;
    logic [LIMIT_BITS-1:0] match_count_reg, match_count_next;
    logic                  stationary_reg, stationary_next;
    logic                  first_reg, first_next;

    // per-event results
    logic [TIME_BITS-1:0]  avg_rate_reg, avg_rate_next;
    logic                  avg_status_reg, avg_status_next;
    logic [TIME_BITS-1:0]  srate_reg, srate_next;
    logic [1:0]            sstatus_reg, sstatus_next;
    logic [TIME_BITS-1:0]  period_reg, period_next;

    // output register
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_BITS-1:0] m_tdata_reg, m_tdata_next;

    logic [TIME_BITS-1:0]  event_time;
    logic                  in_xfer;
    logic                  out_free;
    logic [COUNT_BITS-1:0] count_inc;
    logic [LIMIT_BITS-1:0] mc_upd;
    logic                  two_events;

    lag_req_t lag_req;
    lag_rsp_t lag_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    assign event_time = s_tdata[TIME_BITS-1:0];
    assign s_tready   = (state_reg == S_IDLE);
    assign in_xfer    = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign count_inc  = (events_seen_reg == {COUNT_BITS{1'b1}}) ? events_seen_reg
                                                               : events_seen_reg + COUNT_BITS'(1);
    assign two_events = (events_seen_reg >= COUNT_BITS'(2));

    // first event sees a previous time of zero, so its lag is its own time
    assign lag_req.start      = in_xfer;
    assign lag_req.stamp_now  = event_time;
    assign lag_req.stamp_base = (events_seen_reg == '0) ? '0 : last_time_reg;
    assign lag_req.lag_ref    = last_lag_reg;

    ersm_lag_serial u_lag (
        .clk (clk),
        .rst_n (rst_n),
        .req (lag_req),
        .rsp (lag_rsp)
    );

    ersm_divider u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    // equal-lag counter with ceiling
    assign mc_upd = (match_count_reg < match_limit_reg) ? match_count_reg + LIMIT_BITS'(1)
                                                        : match_count_reg;

    always_comb
    begin
        state_next       = state_reg;
        data_size_next   = data_size_reg;
        match_limit_next = match_limit_reg;
        threshold_next   = threshold_reg;
        events_seen_next = events_seen_reg;
        last_time_next   = last_time_reg;
        last_lag_next    = last_lag_reg;
        match_count_next = match_count_reg;
        stationary_next  = stationary_reg;
        first_next       = first_reg;
        avg_rate_next    = avg_rate_reg;
        avg_status_next  = avg_status_reg;
        srate_next       = srate_reg;
        sstatus_next     = sstatus_reg;
        period_next      = period_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        div_req.start    = 1'b0;
        div_req.num      = DIV_BITS'(count_inc) << FRAC_BITS;
        div_req.den      = event_time;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_DATA_SIZE:   data_size_next   = cfg_wdata[SIZE_BITS-1:0];
                CFG_MATCH_LIMIT: match_limit_next = cfg_wdata[LIMIT_BITS-1:0];
                CFG_THRESHOLD:   threshold_next   = cfg_wdata[LIMIT_BITS-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    first_next       = (events_seen_reg == '0);
                    events_seen_next = count_inc;
                    last_time_next   = event_time;
                    avg_rate_next    = '0;
                    srate_next       = '0;
                    // average rate starts now, beside the lag unit, unless the event time is zero
                    if (event_time == '0)
                    begin
                        avg_status_next = AST_NO_ADVANCE;
                    end
                    else
                    begin
                        avg_status_next = AST_VALID;
                        div_req.start   = 1'b1;
                    end
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (!lag_rsp.busy && !div_rsp.busy)
                begin
                    if (avg_status_reg == AST_VALID)
                    begin
                        avg_rate_next = div_rsp.quot;
                    end
                    last_lag_next = lag_rsp.lag;
                    if (!first_reg)
                    begin
                        if (lag_rsp.equal)
                        begin
                            match_count_next = mc_upd;
                            if (mc_upd >= threshold_reg)
                            begin
                                stationary_next = 1'b1;
                            end
                        end
                        else
                        begin
                            match_count_next = '0;
                            stationary_next  = 1'b0;
                        end
                    end
                    period_next = (two_events && last_time_reg != '0) ? lag_rsp.lag : '0;
                    div_req.num = DIV_BITS'(data_size_reg) << FRAC_BITS;
                    div_req.den = lag_rsp.lag;
                    if (!two_events)
                    begin
                        sstatus_next = SST_FEW_EVENTS;
                        state_next   = S_DONE;
                    end
                    else if (last_time_reg == '0 || lag_rsp.lag == '0)
                    begin
                        sstatus_next = SST_NO_ADVANCE;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        sstatus_next  = SST_VALID;
                        div_req.start = 1'b1;
                        state_next    = S_SDIV;
                    end
                end
            end
            S_SDIV:
            begin
                if (!div_rsp.busy)
                begin
                    srate_next = div_rsp.quot;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_TDATA_BITS'({sstatus_reg, srate_reg, avg_status_reg,
                                                     avg_rate_reg, match_count_reg,
                                                     stationary_reg, period_reg,
                                                     events_seen_reg});
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            data_size_reg   <= '0;
            match_limit_reg <= MATCH_LIMIT_RST;
            threshold_reg   <= THRESHOLD_RST;
            events_seen_reg <= '0;
            last_time_reg   <= '0;
            last_lag_reg    <= '0;
            match_count_reg <= '0;
            stationary_reg  <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            data_size_reg   <= data_size_next;
            match_limit_reg <= match_limit_next;
            threshold_reg   <= threshold_next;
            events_seen_reg <= events_seen_next;
            last_time_reg   <= last_time_next;
            last_lag_reg    <= last_lag_next;
            match_count_reg <= match_count_next;
            stationary_reg  <= stationary_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        first_reg      <= first_next;
        avg_rate_reg   <= avg_rate_next;
        avg_status_reg <= avg_status_next;
        srate_reg      <= srate_next;
        sstatus_reg    <= sstatus_next;
        period_reg     <= period_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // both serial units are quiet whenever a new event can be taken
    `ERSM_ASSERT_NOW(a_idle_units, clk, rst_n, state_reg == S_IDLE, !lag_rsp.busy && !div_rsp.busy)
    // an accepted event always kicks off the lag unit
    `ERSM_ASSERT_NEXT(a_lag_starts, clk, rst_n, in_xfer, lag_rsp.busy && state_reg == S_RUN)
    // an unknown average rate is reported as zero
    `ERSM_ASSERT_NOW(a_avg_zero, clk, rst_n, state_reg == S_DONE && avg_status_reg == AST_NO_ADVANCE, avg_rate_reg == '0)

endmodule

@@ design/ersm_lag_serial.sv @@
// bit-serial lag unit: stamp_now - stamp_base, lsb first, and compare with lag_ref
// depends on ersm_pkg
module ersm_lag_serial (
    input  logic              clk,
    input  logic              rst_n,
    input  ersm_pkg::lag_req_t req,
    output ersm_pkg::lag_rsp_t rsp
);
    import ersm_pkg::*;

    localparam int CNT_W = $clog2(TIME_BITS + 1);

    logic [TIME_BITS-1:0] a_reg, a_next;
    logic [TIME_BITS-1:0] b_reg, b_next;
    logic [TIME_BITS-1:0] c_reg, c_next;
    logic [TIME_BITS-1:0] lag_reg, lag_next;
    logic                 borrow_reg, borrow_next;
    logic                 neq_reg, neq_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy;
    logic                 diff_bit;

    assign busy     = (cnt_reg != '0);
    assign diff_bit = a_reg[0] ^ b_reg[0] ^ borrow_reg;

    always_comb
    begin
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        lag_next    = lag_reg;
        borrow_next = borrow_reg;
        neq_next    = neq_reg;
        cnt_next    = cnt_reg;
        if (req.start && !busy)
        begin
            a_next      = req.stamp_now;
            b_next      = req.stamp_base;
            c_next      = req.lag_ref;
            borrow_next = 1'b0;
            neq_next    = 1'b0;
            cnt_next    = CNT_W'(TIME_BITS);
        end
        else if (busy)
        begin
            // one difference bit per cycle, shifted in from the top
            a_next      = a_reg >> 1;
            b_next      = b_reg >> 1;
            c_next      = c_reg >> 1;
            lag_next    = {diff_bit, lag_reg[TIME_BITS-1:1]};
            borrow_next = (~a_reg[0] & b_reg[0]) | (~(a_reg[0] ^ b_reg[0]) & borrow_reg);
            neq_next    = neq_reg | (diff_bit ^ c_reg[0]);
            cnt_next    = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        lag_reg    <= lag_next;
        borrow_reg <= borrow_next;
        neq_reg    <= neq_next;
    end

    assign rsp.busy  = busy;
    assign rsp.equal = ~neq_reg;
    assign rsp.lag   = lag_reg;

endmodule

@@ design/ersm_divider.sv @@
// radix-2 restoring divider, one quotient bit per cycle, saturating result
// depends on ersm_pkg
module ersm_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  ersm_pkg::div_req_t req,
    output ersm_pkg::div_rsp_t rsp
);
    import ersm_pkg::*;

    localparam int CNT_W = $clog2(DIV_BITS + 1);

    logic [DIV_BITS-1:0]  dvd_reg, dvd_next;
    logic [DIV_BITS-1:0]  quo_reg, quo_next;
    logic [TIME_BITS-1:0] rem_reg, rem_next;
    logic [TIME_BITS-1:0] den_reg, den_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [TIME_BITS:0]   trial;
    logic                 fits;
    logic                 busy;
    logic                 sat;

    assign busy  = (cnt_reg != '0);
    assign trial = {rem_reg, dvd_reg[DIV_BITS-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        dvd_next = dvd_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        if (req.start && !busy)
        begin
            dvd_next = req.num;
            den_next = req.den;
            quo_next = '0;
            rem_next = '0;
            cnt_next = CNT_W'(DIV_BITS);
        end
        else if (busy)
        begin
            dvd_next = dvd_reg << 1;
            quo_next = {quo_reg[DIV_BITS-2:0], fits};
            rem_next = fits ? TIME_BITS'(trial - {1'b0, den_reg}) : TIME_BITS'(trial);
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    // clamp to an all-ones time-width rate
    assign sat = (SAT_BITS'(quo_reg) > SAT_BITS'({TIME_BITS{1'b1}}));

    assign rsp.busy = busy;
    assign rsp.quot = sat ? {TIME_BITS{1'b1}} : TIME_BITS'(quo_reg);

endmodule
